// ===== rtl/assert_macros.svh =====
// Assertion helpers for the RTL (included by v3alu_back).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside reset.
`define V3_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Check that a condition leads to another one in the next cycle.
`define V3_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/v3alu_pkg.sv =====
package v3alu_pkg;

  localparam int unsigned FRAC_BITS_DEF   = 16;
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  typedef logic signed [31:0] fix_t;

  typedef enum logic [2:0] {
    OP_ADD   = 3'd0,
    OP_SUB   = 3'd1,
    OP_SCALE = 3'd2,
    OP_DOT   = 3'd3,
    OP_CROSS = 3'd4,
    OP_MAG   = 3'd5,
    OP_NORM  = 3'd6,
    OP_NONE  = 3'd7
  } op_e;

  typedef struct packed {
    op_e            op;
    fix_t [2:0]     a;
    fix_t [2:0]     b;
    fix_t           s;
  } req_t;

  typedef struct packed {
    logic           norm;
    logic [63:0]    sq;
    fix_t [2:0]     a;
  } root_req_t;

  typedef struct packed {
    fix_t [2:0]     r;
    fix_t           sc;
    logic           status;
    logic           ovf;
  } res_t;

  typedef struct packed {
    fix_t           v;
    logic           ovf;
  } sat_t;

  localparam logic signed [65:0] FIX_MAX = 66'sd2147483647;
  localparam logic signed [65:0] FIX_MIN = -66'sd2147483648;

  // Clip a wide value to the Q range and flag it.
  function automatic sat_t sat66(input logic signed [65:0] v);
    sat_t o;
    if (v > FIX_MAX) begin
      o.v   = 32'sh7FFFFFFF;
      o.ovf = 1'b1;
    end else if (v < FIX_MIN) begin
      o.v   = 32'sh80000000;
      o.ovf = 1'b1;
    end else begin
      o.v   = v[31:0];
      o.ovf = 1'b0;
    end
    return o;
  endfunction

endpackage

// ===== rtl/v3alu_front.sv =====
module v3alu_front #(
  parameter int unsigned Depth = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [2:0]          kind_i,
  input  v3alu_pkg::fix_t     a_x_i,
  input  v3alu_pkg::fix_t     a_y_i,
  input  v3alu_pkg::fix_t     a_z_i,
  input  v3alu_pkg::fix_t     b_x_i,
  input  v3alu_pkg::fix_t     b_y_i,
  input  v3alu_pkg::fix_t     b_z_i,
  input  v3alu_pkg::fix_t     scale_factor_i,
  output logic                busy_o,
  output logic                req_valid_o,
  output v3alu_pkg::req_t     req_o,
  input  logic                pop_i
);
  import v3alu_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  req_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push;
  op_e             op;
  req_t            entry;

  // decode the operation code; every 3-bit value names an operation
  assign op = op_e'(kind_i);

  assign entry.op = op;
  assign entry.a  = {a_z_i, a_y_i, a_x_i};
  assign entry.b  = {b_z_i, b_y_i, b_x_i};
  assign entry.s  = scale_factor_i;

  assign busy_o      = (cnt_q == CntW'(Depth));
  assign push        = start_i && !busy_o;
  assign req_valid_o = (cnt_q != '0);
  assign req_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= entry;
    end
  end

endmodule

// ===== rtl/v3alu_root.sv =====
module v3alu_root #(
  parameter int unsigned FracBits = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  v3alu_pkg::root_req_t  req_i,
  output logic                  busy_o,
  output logic                  done_o,
  output v3alu_pkg::res_t       res_o
);
  import v3alu_pkg::*;

  localparam int unsigned NW   = 33 + FracBits;
  localparam int unsigned CntW = $clog2(NW);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SQRT  = 3'd1;
  localparam logic [2:0] ST_ROUND = 3'd2;
  localparam logic [2:0] ST_SETUP = 3'd3;
  localparam logic [2:0] ST_DIV   = 3'd4;
  localparam logic [2:0] ST_SIGN  = 3'd5;
  localparam logic [2:0] ST_DONE  = 3'd6;

  logic [2:0]      state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [63:0]     x_q, x_d, r_q, r_d, bit_q, bit_d, trial;
  logic [32:0]     m_q, m_d;
  logic            norm_q, norm_d;
  logic [2:0]      neg_q, neg_d;
  logic [31:0]     abs_q [3];
  logic [31:0]     abs_d [3];
  logic [NW-1:0]   num_q [3];
  logic [NW-1:0]   num_d [3];
  logic [34:0]     rem_q [3];
  logic [34:0]     rem_d [3];
  logic [34:0]     rem_s [3];
  logic [33:0]     dvs;
  res_t            res_q, res_d;
  sat_t            sv [3];
  sat_t            sm;

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = (state_q == ST_DONE);
  assign res_o  = res_q;
  assign trial  = r_q + bit_q;
  assign dvs    = {m_q, 1'b0};

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    x_d     = x_q;
    r_d     = r_q;
    bit_d   = bit_q;
    m_d     = m_q;
    norm_d  = norm_q;
    neg_d   = neg_q;
    res_d   = res_q;
    sm      = sat66($signed({33'd0, m_q}));
    for (int i = 0; i < 3; i++) begin
      abs_d[i] = abs_q[i];
      num_d[i] = num_q[i];
      rem_d[i] = rem_q[i];
      rem_s[i] = {rem_q[i][33:0], num_q[i][NW-1]};
      sv[i]    = sat66(neg_q[i] ? -$signed(66'(num_q[i])) : $signed(66'(num_q[i])));
    end
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          x_d     = req_i.sq;
          r_d     = '0;
          bit_d   = 64'd1 << 62;
          cnt_d   = '0;
          norm_d  = req_i.norm;
          for (int i = 0; i < 3; i++) begin
            neg_d[i] = req_i.a[i][31];
            abs_d[i] = req_i.a[i][31] ? (~req_i.a[i] + 32'd1) : req_i.a[i];
          end
          state_d = ST_SQRT;
        end
      end
      ST_SQRT: begin
        // one root digit per cycle
        if (x_q >= trial) begin
          x_d = x_q - trial;
          r_d = (r_q >> 1) + bit_q;
        end else begin
          r_d = r_q >> 1;
        end
        bit_d = bit_q >> 2;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntW'(31)) begin
          cnt_d   = '0;
          state_d = ST_ROUND;
        end
      end
      ST_ROUND: begin
        // remainder above root: round up
        m_d     = r_q[32:0] + 33'(x_q > r_q);
        state_d = ST_SETUP;
      end
      ST_SETUP: begin
        res_d = '0;
        if (!norm_q) begin
          res_d.sc  = sm.v;
          res_d.ovf = sm.ovf;
          state_d   = ST_DONE;
        end else if (m_q == '0) begin
          res_d.status = 1'b1;
          state_d      = ST_DONE;
        end else begin
          for (int i = 0; i < 3; i++) begin
            num_d[i] = {abs_q[i], FracBits'(0), 1'b0} + NW'(m_q);
            rem_d[i] = '0;
          end
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        // one quotient bit per cycle, (2n + m) / 2m
        for (int i = 0; i < 3; i++) begin
          if (rem_s[i] >= 35'(dvs)) begin
            rem_d[i] = rem_s[i] - 35'(dvs);
            num_d[i] = {num_q[i][NW-2:0], 1'b1};
          end else begin
            rem_d[i] = rem_s[i];
            num_d[i] = {num_q[i][NW-2:0], 1'b0};
          end
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntW'(NW - 1)) begin
          cnt_d   = '0;
          state_d = ST_SIGN;
        end
      end
      ST_SIGN: begin
        for (int i = 0; i < 3; i++) begin
          res_d.r[i] = sv[i].v;
        end
        res_d.ovf = sv[0].ovf | sv[1].ovf | sv[2].ovf;
        state_d   = ST_DONE;
      end
      ST_DONE: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    r_q    <= r_d;
    bit_q  <= bit_d;
    m_q    <= m_d;
    norm_q <= norm_d;
    neg_q  <= neg_d;
    res_q  <= res_d;
    abs_q  <= abs_d;
    num_q  <= num_d;
    rem_q  <= rem_d;
  end

endmodule

// ===== rtl/v3alu_back.sv =====
`include "assert_macros.svh"

module v3alu_back #(
  parameter int unsigned FracBits = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  input  v3alu_pkg::req_t   req_i,
  output logic              pop_o,
  output logic              valid_o,
  output v3alu_pkg::res_t   res_o
);
  import v3alu_pkg::*;

  localparam logic signed [65:0] Half = 66'sd1 <<< (FracBits - 1);

  // stage 1: products and sums
  logic               s1_valid_q;
  op_e                s1_op_q;
  logic signed [63:0] p_q [6];
  logic signed [63:0] prod [6];
  logic signed [31:0] ma [6];
  logic signed [31:0] mb [6];
  logic signed [32:0] add_q [3];
  logic signed [32:0] add_d [3];
  fix_t [2:0]         s1_a_q;

  // stage 2: accumulate
  logic               s2_valid_q;
  op_e                s2_op_q;
  logic signed [65:0] acc_q [3];
  logic signed [65:0] acc_d [3];
  logic signed [65:0] rnd [3];
  fix_t [2:0]         s2_a_q;

  logic               blk_q;
  logic               s2_out, root_start, root_busy, root_done;
  root_req_t          root_req;
  res_t               root_res, res_q, res_d;
  logic               valid_q;
  sat_t               sr [3];
  sat_t               sa [3];

  logic signed [31:0] ax, ay, az, bx, by, bz, sf;

  assign ax = $signed(req_i.a[0]);
  assign ay = $signed(req_i.a[1]);
  assign az = $signed(req_i.a[2]);
  assign bx = $signed(req_i.b[0]);
  assign by = $signed(req_i.b[1]);
  assign bz = $signed(req_i.b[2]);
  assign sf = $signed(req_i.s);

  // hold issue while a root request is in flight
  assign pop_o = req_valid_i && !blk_q;

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      ma[i] = '0;
      mb[i] = '0;
    end
    case (req_i.op)
      OP_SCALE: begin
        ma[0] = ax; mb[0] = sf;
        ma[1] = ay; mb[1] = sf;
        ma[2] = az; mb[2] = sf;
      end
      OP_DOT: begin
        ma[0] = ax; mb[0] = bx;
        ma[1] = ay; mb[1] = by;
        ma[2] = az; mb[2] = bz;
      end
      OP_CROSS: begin
        ma[0] = ay; mb[0] = bz;
        ma[1] = az; mb[1] = by;
        ma[2] = az; mb[2] = bx;
        ma[3] = ax; mb[3] = bz;
        ma[4] = ax; mb[4] = by;
        ma[5] = ay; mb[5] = bx;
      end
      OP_MAG, OP_NORM: begin
        ma[0] = ax; mb[0] = ax;
        ma[1] = ay; mb[1] = ay;
        ma[2] = az; mb[2] = az;
      end
      default: begin
      end
    endcase
    add_d[0] = (req_i.op == OP_SUB) ? 33'(ax) - 33'(bx) : 33'(ax) + 33'(bx);
    add_d[1] = (req_i.op == OP_SUB) ? 33'(ay) - 33'(by) : 33'(ay) + 33'(by);
    add_d[2] = (req_i.op == OP_SUB) ? 33'(az) - 33'(bz) : 33'(az) + 33'(bz);
  end

  for (genvar g = 0; g < 6; g++) begin : g_mul
    assign prod[g] = ma[g] * mb[g];
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc_d[i] = '0;
    end
    case (s1_op_q)
      OP_ADD, OP_SUB: begin
        for (int i = 0; i < 3; i++) acc_d[i] = 66'(add_q[i]);
      end
      OP_SCALE: begin
        for (int i = 0; i < 3; i++) acc_d[i] = 66'(p_q[i]);
      end
      OP_DOT, OP_MAG, OP_NORM: begin
        acc_d[0] = 66'(p_q[0]) + 66'(p_q[1]) + 66'(p_q[2]);
      end
      OP_CROSS: begin
        acc_d[0] = 66'(p_q[0]) - 66'(p_q[1]);
        acc_d[1] = 66'(p_q[2]) - 66'(p_q[3]);
        acc_d[2] = 66'(p_q[4]) - 66'(p_q[5]);
      end
      default: begin
      end
    endcase
  end

  // round half up, then clip; sums and differences are clipped unrounded
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rnd[i] = (acc_q[i] + Half) >>> FracBits;
      sr[i]  = sat66(rnd[i]);
      sa[i]  = sat66(acc_q[i]);
    end
    res_d = '0;
    case (s2_op_q)
      OP_ADD, OP_SUB: begin
        for (int i = 0; i < 3; i++) res_d.r[i] = sa[i].v;
        res_d.ovf = sa[0].ovf | sa[1].ovf | sa[2].ovf;
      end
      OP_SCALE, OP_CROSS: begin
        for (int i = 0; i < 3; i++) res_d.r[i] = sr[i].v;
        res_d.ovf = sr[0].ovf | sr[1].ovf | sr[2].ovf;
      end
      OP_DOT: begin
        res_d.sc  = sr[0].v;
        res_d.ovf = sr[0].ovf;
      end
      default: begin
      end
    endcase
    if (root_done) begin
      res_d = root_res;
    end
  end

  assign root_start    = s2_valid_q && (s2_op_q inside {OP_MAG, OP_NORM});
  assign s2_out        = s2_valid_q && !root_start;
  assign root_req.norm = (s2_op_q == OP_NORM);
  assign root_req.sq   = acc_q[0][63:0];
  assign root_req.a    = s2_a_q;

  v3alu_root #(
    .FracBits (FracBits)
  ) u_root (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (root_start),
    .req_i   (root_req),
    .busy_o  (root_busy),
    .done_o  (root_done),
    .res_o   (root_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      valid_q    <= 1'b0;
      blk_q      <= 1'b0;
    end else begin
      s1_valid_q <= pop_o;
      s2_valid_q <= s1_valid_q;
      valid_q    <= s2_out || root_done;
      if (pop_o && (req_i.op inside {OP_MAG, OP_NORM})) begin
        blk_q <= 1'b1;
      end else if (root_done) begin
        blk_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s1_op_q <= req_i.op;
    s1_a_q  <= req_i.a;
    p_q     <= prod;
    add_q   <= add_d;
    s2_op_q <= s1_op_q;
    s2_a_q  <= s1_a_q;
    acc_q   <= acc_d;
    res_q   <= res_d;
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

  `V3_ASSERT(a_root_idle, clk_i, rst_ni, root_start |-> !root_busy, "root start while busy")
  `V3_ASSERT(a_no_clash, clk_i, rst_ni, !(root_done && s2_out), "result collision")
  `V3_ASSERT_NEXT(a_unblock, clk_i, rst_ni, root_done, !blk_q, "issue still held")

endmodule

// ===== rtl/vec3_alu_unit.sv =====
// Sum, difference, scale, dot and cross pass stage 1 (products and sums), stage 2
// (accumulate) and the result register, which strobes valid_o. Magnitude and normalize
// use a shared root/divide sequencer (one root digit, then one quotient bit per cycle).
// Throughput: one item per cycle for linear ops; issue pauses while the sequencer runs.
// Reset: asynchronous, active low; empties the request queue and drops work in flight.
// The receiver cannot stall: each result shows for exactly one cycle.
module vec3_alu_unit #(
  parameter int unsigned FRAC_BITS   = v3alu_pkg::FRAC_BITS_DEF,
  parameter int unsigned QUEUE_DEPTH = v3alu_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic [2:0]          kind_i,
  input  v3alu_pkg::fix_t     a_x_i,
  input  v3alu_pkg::fix_t     a_y_i,
  input  v3alu_pkg::fix_t     a_z_i,
  input  v3alu_pkg::fix_t     b_x_i,
  input  v3alu_pkg::fix_t     b_y_i,
  input  v3alu_pkg::fix_t     b_z_i,
  input  v3alu_pkg::fix_t     scale_factor_i,
  output logic                valid_o,
  output v3alu_pkg::fix_t     r_x_o,
  output v3alu_pkg::fix_t     r_y_o,
  output v3alu_pkg::fix_t     r_z_o,
  output v3alu_pkg::fix_t     scalar_out_o,
  output logic                status_o,
  output logic                overflow_o
);
  import v3alu_pkg::*;

  // request handed from the front queue to the execution side
  req_t req;
  logic req_valid, pop;
  res_t res;

  // front: decode the request and hold it in a short queue
  v3alu_front #(
    .Depth (QUEUE_DEPTH)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .kind_i         (kind_i),
    .a_x_i          (a_x_i),
    .a_y_i          (a_y_i),
    .a_z_i          (a_z_i),
    .b_x_i          (b_x_i),
    .b_y_i          (b_y_i),
    .b_z_i          (b_z_i),
    .scale_factor_i (scale_factor_i),
    .busy_o         (busy_o),
    .req_valid_o    (req_valid),
    .req_o          (req),
    .pop_i          (pop)
  );

  // back: three-stage multiply/accumulate/round pipe plus root and divide sequencer
  v3alu_back #(
    .FracBits (FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid),
    .req_i       (req),
    .pop_o       (pop),
    .valid_o     (valid_o),
    .res_o       (res)
  );

  assign r_x_o        = res.r[0];
  assign r_y_o        = res.r[1];
  assign r_z_o        = res.r[2];
  assign scalar_out_o = res.sc;
  assign status_o     = res.status;
  assign overflow_o   = res.ovf;

endmodule
